// ===== rtl/tcse_pkg.sv =====
package tcse_pkg;

	localparam int MAX_PAYLOAD = 1460;
	localparam int MAX_RES     = 3;

	typedef logic [31:0] seq_t;
	typedef logic [10:0] len_t;
	typedef logic [19:0] bytes_t;
	typedef logic [15:0] tmo_t;
	typedef logic [7:0]  flags_t;
	typedef logic [1:0]  rcnt_t;
	typedef logic [1:0]  act_t;
	typedef logic [1:0]  cfg_idx_t;

	localparam len_t MAX_REQ = len_t'(MAX_PAYLOAD);

	localparam flags_t FL_FIN = 8'h01;
	localparam flags_t FL_SYN = 8'h02;
	localparam flags_t FL_RST = 8'h04;
	localparam flags_t FL_PSH = 8'h08;
	localparam flags_t FL_ACK = 8'h10;

	localparam act_t ACT_OPEN = 2'd0;
	localparam act_t ACT_SEG  = 2'd1;
	localparam act_t ACT_TICK = 2'd2;

	localparam logic KIND_SEG = 1'b0;
	localparam logic KIND_FIN = 1'b1;

	localparam cfg_idx_t CFG_HANDSHAKE = 2'd0;
	localparam cfg_idx_t CFG_RECEIVE   = 2'd1;
	localparam cfg_idx_t CFG_CLOSE     = 2'd2;

	localparam tmo_t HANDSHAKE_TMO_RST = 16'd3000;
	localparam tmo_t RECEIVE_TMO_RST   = 16'd3000;
	localparam tmo_t CLOSE_TMO_RST     = 16'd500;

	typedef struct packed {
		tmo_t handshake;
		tmo_t receive;
		tmo_t close;
	} cfg_t;

	typedef struct packed {
		act_t   action;
		seq_t   initial_seq;
		len_t   req_size;
		bytes_t response_capacity;
		seq_t   seg_seq;
		seq_t   seg_ack;
		flags_t seg_flags;
		len_t   seg_payload_len;
	} cmd_t;

	typedef struct packed {
		logic   kind;
		seq_t   seq;
		seq_t   ack;
		flags_t flags;
		logic   carries;
		len_t   copy;
	} slot_t;

	typedef struct packed {
		rcnt_t                cnt;
		slot_t [MAX_RES-1:0]  slot;
		bytes_t               total;
		logic                 success;
	} bundle_t;

endpackage

// ===== rtl/tcse_if.sv =====
interface tcse_cmd_if import tcse_pkg::*; ();
	logic   valid;
	logic   ready;
	act_t   action;
	seq_t   initial_seq;
	len_t   req_size;
	bytes_t response_capacity;
	seq_t   seg_seq;
	seq_t   seg_ack;
	flags_t seg_flags;
	len_t   seg_payload_len;

	modport source (
		output valid, action, initial_seq, req_size, response_capacity,
		       seg_seq, seg_ack, seg_flags, seg_payload_len,
		input  ready
	);
	modport sink (
		input  valid, action, initial_seq, req_size, response_capacity,
		       seg_seq, seg_ack, seg_flags, seg_payload_len,
		output ready
	);
endinterface

interface tcse_res_if import tcse_pkg::*; ();
	logic   valid;
	logic   ready;
	logic   kind;
	seq_t   out_seq;
	seq_t   out_ack;
	flags_t out_flags;
	logic   carries_request;
	len_t   keep_len;
	bytes_t kept_total;
	logic   success;
	logic   last_result;

	modport source (
		output valid, kind, out_seq, out_ack, out_flags, carries_request, keep_len,
		       kept_total, success, last_result,
		input  ready
	);
	modport sink (
		input  valid, kind, out_seq, out_ack, out_flags, carries_request, keep_len,
		       kept_total, success, last_result,
		output ready
	);
endinterface

// ===== rtl/tcse_cfg.sv =====
module tcse_cfg import tcse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     we,
	input  cfg_idx_t index,
	input  tmo_t     data,
	output cfg_t     cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.handshake <= HANDSHAKE_TMO_RST;
			cfg_q.receive   <= RECEIVE_TMO_RST;
			cfg_q.close     <= CLOSE_TMO_RST;
		end else if (we) begin
			unique case (index)
				CFG_HANDSHAKE: cfg_q.handshake <= data;
				CFG_RECEIVE:   cfg_q.receive   <= data;
				CFG_CLOSE:     cfg_q.close     <= data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== rtl/tcse_step.sv =====
module tcse_step import tcse_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    fire,
	input  cmd_t    cmd,
	input  cfg_t    cfg,
	output bundle_t bnd
);

	typedef enum logic [2:0] {
		PH_IDLE       = 3'd0,
		PH_SYN        = 3'd1,
		PH_RECV       = 3'd2,
		PH_CLOSE_OWN  = 3'd3,
		PH_CLOSE_PEER = 3'd4
	} phase_t;

	phase_t phase_q, phase_d;
	seq_t   own_q, own_d;
	seq_t   peer_q, peer_d;
	len_t   req_q, req_d;
	bytes_t bc_q, bc_d;
	bytes_t cap_q, cap_d;
	tmo_t   cd_q, cd_d;

	function automatic slot_t mk_seg(seq_t s, seq_t a, flags_t f, logic c, len_t cp);
		slot_t r;
		r.kind    = KIND_SEG;
		r.seq     = s;
		r.ack     = a;
		r.flags   = f;
		r.carries = c;
		r.copy    = cp;
		return r;
	endfunction

	function automatic slot_t mk_fin();
		slot_t r;
		r      = '0;
		r.kind = KIND_FIN;
		return r;
	endfunction

	always_comb begin
		seq_t   own_inc;
		seq_t   own_post;
		seq_t   peer_syn;
		seq_t   peer_rx;
		bytes_t room;
		len_t   copy;
		logic   seg_fin;
		logic   bad_synack;
		logic   expired;

		own_inc  = own_q + 32'd1;
		own_post = own_inc + seq_t'(req_q);
		peer_syn = cmd.seg_seq + 32'd1;
		seg_fin  = (cmd.seg_flags & FL_FIN) != '0;
		bad_synack = ((cmd.seg_flags & FL_RST) != '0) || ((cmd.seg_flags & FL_SYN) == '0) ||
		             ((cmd.seg_flags & FL_ACK) == '0) || (cmd.seg_ack != own_inc);
		room     = (cap_q > bc_q) ? (cap_q - bc_q) : '0;
		copy     = (bytes_t'(cmd.seg_payload_len) < room) ? cmd.seg_payload_len : len_t'(room);
		peer_rx  = peer_q + seq_t'(cmd.seg_payload_len) + seq_t'(seg_fin);
		expired  = cd_q <= 16'd1;

		phase_d = phase_q;
		own_d   = own_q;
		peer_d  = peer_q;
		req_d   = req_q;
		bc_d    = bc_q;
		cap_d   = cap_q;
		cd_d    = cd_q;
		bnd     = '0;

		unique case (phase_q)
			PH_IDLE: begin
				if (cmd.action == ACT_OPEN) begin
					own_d   = cmd.initial_seq;
					peer_d  = '0;
					req_d   = (cmd.req_size > MAX_REQ) ? MAX_REQ : cmd.req_size;
					cap_d   = cmd.response_capacity;
					bc_d    = '0;
					cd_d    = cfg.handshake;
					phase_d = PH_SYN;
					bnd.cnt = 2'd1;
					bnd.slot[0] = mk_seg(cmd.initial_seq, '0, FL_SYN, 1'b0, '0);
				end
			end
			PH_SYN: begin
				if (cmd.action == ACT_SEG) begin
					if (bad_synack) begin
						phase_d = PH_IDLE;
						bnd.cnt = 2'd1;
						bnd.slot[0] = mk_fin();
					end else begin
						own_d   = own_post;
						peer_d  = peer_syn;
						phase_d = PH_RECV;
						cd_d    = cfg.receive;
						bnd.cnt = 2'd2;
						bnd.slot[0] = mk_seg(own_inc, peer_syn, FL_ACK, 1'b0, '0);
						bnd.slot[1] = mk_seg(own_inc, peer_syn, FL_PSH | FL_ACK, 1'b1, '0);
						// zero capacity: close straight after the request
						if (bc_q >= cap_q) begin
							phase_d = PH_CLOSE_OWN;
							cd_d    = cfg.close;
							bnd.cnt = 2'd3;
							bnd.slot[2] = mk_seg(own_post, peer_syn, FL_FIN | FL_ACK, 1'b0, '0);
						end
					end
				end else if (cmd.action == ACT_TICK) begin
					if (expired) begin
						cd_d    = '0;
						phase_d = PH_IDLE;
						bnd.cnt = 2'd1;
						bnd.slot[0] = mk_fin();
					end else begin
						cd_d = cd_q - 16'd1;
					end
				end
			end
			PH_RECV: begin
				if (cmd.action == ACT_SEG) begin
					bc_d    = bc_q + bytes_t'(copy);
					peer_d  = peer_rx;
					bnd.cnt = 2'd1;
					bnd.slot[0] = mk_seg(own_q, peer_rx, FL_ACK, 1'b0, copy);
					if (seg_fin || (bc_q + bytes_t'(copy) >= cap_q)) begin
						phase_d = seg_fin ? PH_CLOSE_PEER : PH_CLOSE_OWN;
						cd_d    = cfg.close;
						bnd.cnt = 2'd2;
						bnd.slot[1] = mk_seg(own_q, peer_rx, FL_FIN | FL_ACK, 1'b0, '0);
					end
				end else if (cmd.action == ACT_TICK) begin
					if (expired) begin
						phase_d = PH_CLOSE_OWN;
						cd_d    = cfg.close;
						bnd.cnt = 2'd1;
						bnd.slot[0] = mk_seg(own_q, peer_q, FL_FIN | FL_ACK, 1'b0, '0);
					end else begin
						cd_d = cd_q - 16'd1;
					end
				end
			end
			PH_CLOSE_OWN, PH_CLOSE_PEER: begin
				if (cmd.action == ACT_SEG) begin
					phase_d = PH_IDLE;
					bnd.cnt = 2'd1;
					bnd.slot[0] = mk_fin();
					if (phase_q == PH_CLOSE_OWN && seg_fin) begin
						peer_d  = peer_syn;
						bnd.cnt = 2'd2;
						bnd.slot[0] = mk_seg(own_inc, peer_syn, FL_ACK, 1'b0, '0);
						bnd.slot[1] = mk_fin();
					end
				end else if (cmd.action == ACT_TICK) begin
					if (expired) begin
						cd_d    = '0;
						phase_d = PH_IDLE;
						bnd.cnt = 2'd1;
						bnd.slot[0] = mk_fin();
					end else begin
						cd_d = cd_q - 16'd1;
					end
				end
			end
			default: ;
		endcase

		// every result of one item sees the count as it stands after the item
		bnd.total   = bc_d;
		bnd.success = bc_d != '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			own_q   <= '0;
			peer_q  <= '0;
			req_q   <= '0;
			bc_q    <= '0;
			cap_q   <= '0;
			cd_q    <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			own_q   <= own_d;
			peer_q  <= peer_d;
			req_q   <= req_d;
			bc_q    <= bc_d;
			cap_q   <= cap_d;
			cd_q    <= cd_d;
		end
	end

endmodule

// ===== rtl/tcse_out.sv =====
module tcse_out import tcse_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  bundle_t       bnd,
	output logic          free,
	tcse_res_if.source    res
);

	bundle_t bnd_q;
	logic    vld_q;
	rcnt_t   idx_q;
	slot_t   cur;
	logic    take;
	logic    last;

	assign cur  = bnd_q.slot[idx_q];
	assign take = res.valid & res.ready;
	assign last = idx_q == (bnd_q.cnt - rcnt_t'(1));
	assign free = !vld_q || (take && last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load && bnd.cnt != '0) begin
			vld_q <= 1'b1;
			idx_q <= '0;
		end else if (take) begin
			if (last) begin
				vld_q <= 1'b0;
			end else begin
				idx_q <= idx_q + rcnt_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && bnd.cnt != '0) begin
			bnd_q <= bnd;
		end
	end

	assign res.valid           = vld_q;
	assign res.kind            = cur.kind;
	assign res.out_seq         = cur.seq;
	assign res.out_ack         = cur.ack;
	assign res.out_flags       = cur.flags;
	assign res.carries_request = cur.carries;
	assign res.keep_len        = cur.copy;
	assign res.kept_total      = bnd_q.total;
	assign res.success         = cur.kind & bnd_q.success;
	assign res.last_result     = last;

endmodule

// ===== rtl/tcp_client_session_engine_core.sv =====
// An accepted item is registered in the input stage, processed once the output register
// is free, and its results are registered in the output register.
// Throughput: one item per cycle when each causes at most one result and res.ready is
// high; an item with several results (up to 3) holds the output register until all are taken.
// Reset (arst_n low, asynchronous): session idle, counters zero, timeouts at defaults.
module tcp_client_session_engine_core import tcse_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	tcse_cmd_if.sink cmd,
	tcse_res_if.source res,
	input  logic     cfg_we,
	input  cfg_idx_t cfg_index,
	input  tmo_t     cfg_data
);

	cmd_t    cmd_s1;
	logic    vld_s1;
	logic    free;
	logic    fire;
	cfg_t    cfg;
	bundle_t bnd;

	assign fire      = vld_s1 & free;
	assign cmd.ready = !vld_s1 || free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (cmd.ready) begin
			vld_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1.action            <= cmd.action;
			cmd_s1.initial_seq       <= cmd.initial_seq;
			cmd_s1.req_size          <= cmd.req_size;
			cmd_s1.response_capacity <= cmd.response_capacity;
			cmd_s1.seg_seq           <= cmd.seg_seq;
			cmd_s1.seg_ack           <= cmd.seg_ack;
			cmd_s1.seg_flags         <= cmd.seg_flags;
			cmd_s1.seg_payload_len   <= cmd.seg_payload_len;
		end
	end

	tcse_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (cfg_we),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	tcse_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.cmd    (cmd_s1),
		.cfg    (cfg),
		.bnd    (bnd)
	);

	tcse_out u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.bnd    (bnd),
		.free   (free),
		.res    (res)
	);

endmodule

// ===== rtl/tcse_checker.sv =====
module tcse_checker import tcse_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   res_valid,
	input logic   res_ready,
	input logic   kind,
	input seq_t   out_seq,
	input seq_t   out_ack,
	input flags_t out_flags,
	input logic   carries_request,
	input len_t   keep_len,
	input logic   success,
	input logic   last_result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result item dropped while stalled");

	a_finish_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_FIN |->
		out_seq == '0 && out_ack == '0 && out_flags == '0 && last_result)
		else $error("finish item malformed or not last");

	a_seg_no_success: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_SEG |-> !success)
		else $error("segment item flags success");

	a_request_flags: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && carries_request |->
		out_flags == (FL_PSH | FL_ACK) && keep_len == '0 && kind == KIND_SEG)
		else $error("request segment with wrong flags");

	a_copy_on_ack: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && keep_len != '0 |-> out_flags == FL_ACK && kind == KIND_SEG)
		else $error("copy length outside a data ACK");

endmodule

bind tcp_client_session_engine_core tcse_checker u_chk (
	.clk             (clk),
	.arst_n          (arst_n),
	.res_valid       (res.valid),
	.res_ready       (res.ready),
	.kind            (res.kind),
	.out_seq         (res.out_seq),
	.out_ack         (res.out_ack),
	.out_flags       (res.out_flags),
	.carries_request (res.carries_request),
	.keep_len        (res.keep_len),
	.success         (res.success),
	.last_result     (res.last_result)
);
